// ----- hdl/multilevel_round_robin_scheduler_defines.svh -----
// Assertion macros shared by the scheduler RTL.
// Stand-alone header; the files that check themselves include it.
`ifndef MULTILEVEL_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define MRRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define MRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mrrs_pkg.sv -----
// Types, codes and defaults of the multilevel round-robin scheduler.
// No dependencies; used by the scheduler top and its testbench.
package mrrs_pkg;

	// Sizing defaults
	localparam int MAX_TASKS_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int NUM_QUEUES      = 3;
	localparam int QSEL_W          = 2;

	// Field widths
	localparam int PRIO_W    = 4;
	localparam int ADDR_W    = 64;
	localparam int CPU_W     = 4;
	localparam int TASK_ID_W = 6;
	localparam int SLICE_W   = 12;
	localparam int QUANTUM_W = 8;
	localparam int MULT_W    = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MULT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MED_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_CPU   = 3'd4;

	// Register reset values
	localparam logic [QUANTUM_W-1:0] QUANTUM_RST   = 8'd5;
	localparam logic [MULT_W-1:0]    IDLE_MULT_RST = 4'd5;
	localparam logic [PRIO_W-1:0]    HIGH_CODE_RST = 4'd3;
	localparam logic [PRIO_W-1:0]    MED_CODE_RST  = 4'd2;
	localparam logic [CPU_W-1:0]     OWN_CPU_RST   = 4'd0;

	// Queue selectors
	localparam logic [QSEL_W-1:0] Q_HIGH = 2'd0;
	localparam logic [QSEL_W-1:0] Q_MED  = 2'd1;
	localparam logic [QSEL_W-1:0] Q_LOW  = 2'd2;

	// Commands
	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef enum logic [2:0] {
		ST_CREATED    = 3'd0,
		ST_FULL       = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_IDLE       = 3'd3,
		ST_OTHER_CPU  = 3'd4
	} status_t;

	typedef struct packed {
		logic              cmd;
		logic [PRIO_W-1:0] priority_req;
		logic [ADDR_W-1:0] entry_addr;
		logic [CPU_W-1:0]  target_cpu;
	} req_item_t;

	typedef struct packed {
		status_t              status;
		logic [TASK_ID_W-1:0] task_id;
		logic [ADDR_W-1:0]    task_addr;
		logic [SLICE_W-1:0]   slice_ticks;
	} rsp_item_t;

endpackage

// ----- hdl/multilevel_round_robin_scheduler.sv -----
// Multilevel priority round-robin scheduler for one CPU.
// Depends on mrrs_pkg, mrrs_ram and multilevel_round_robin_scheduler_defines.svh.
//
// Request channel (req_valid / req_stall / req_data): a create request adds a
// task to the high, medium or low run queue by its priority code; a tick
// request dispatches the next task of the highest non-empty queue, round robin.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// request, in order. Config channel (cfg_valid / cfg_ready / cfg_index /
// cfg_data): always ready; write only while the block is idle.
// Flow: a create or an idle tick passes from acceptance through the result
// register to the response register; a dispatching tick first reads the queue
// slot, then the task table (both synchronous RAMs). One request is in
// flight at a time; req_stall is high from acceptance until its response has
// moved into the output register, so the next request may enter the cycle
// after that even while the response is still held.
// Reset: queues empty, round-robin pointers at the head marker, task numbering
// at zero, registers at defaults. The task and queue memories need no clearing.
// A stalled response holds in the output register; a finished response waits
// in the block until the output register frees, and requests stall meanwhile.
`include "multilevel_round_robin_scheduler_defines.svh"

module multilevel_round_robin_scheduler #(
	parameter int MAX_TASKS   = mrrs_pkg::MAX_TASKS_DEF,
	parameter int QUEUE_DEPTH = mrrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  mrrs_pkg::req_item_t                 req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output mrrs_pkg::rsp_item_t                 rsp_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import mrrs_pkg::*;

	localparam int IW          = $clog2(MAX_TASKS);
	localparam int NW          = $clog2(MAX_TASKS + 1);
	localparam int QIW         = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);
	localparam int QRAM_DEPTH  = NUM_QUEUES << QIW;
	localparam int QAW         = $clog2(QRAM_DEPTH);
	localparam int TRAM_W      = PRIO_W + ADDR_W;
	localparam int SW          = ((CW + 2) > NW) ? (CW + 2) : NW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SLOT,
		S_TASK,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q  [NUM_QUEUES];
	logic [CW-1:0]      pick_q [NUM_QUEUES];
	logic [NW-1:0]      next_q;
	logic [IW-1:0]      id_q;
	rsp_item_t          res_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_data_q;

	logic [QUANTUM_W-1:0] quantum_q;
	logic [MULT_W-1:0]    idle_mult_q;
	logic [PRIO_W-1:0]    high_code_q;
	logic [PRIO_W-1:0]    med_code_q;
	logic [CPU_W-1:0]     own_cpu_q;

	logic              accept;
	logic              is_tick;
	logic [QSEL_W-1:0] create_q_sel;
	logic [QSEL_W-1:0] tick_q_sel;
	logic              any_ready;
	logic [QSEL_W-1:0] sel_q;
	logic [CW-1:0]     cnt_sel;
	logic [CW-1:0]     pick_sel;
	logic [CW-1:0]     pick_inc;
	logic [CW-1:0]     new_pick;
	logic              other_cpu;
	logic              table_full;
	logic              do_create;
	logic              do_tick;
	logic              out_free;
	logic [SLICE_W-1:0] idle_slice;
	logic [SLICE_W-1:0] task_slice;

	logic              q_wr_en;
	logic [QAW-1:0]    q_wr_addr;
	logic              q_rd_en;
	logic [QAW-1:0]    q_rd_addr;
	logic [IW-1:0]     q_rd_data;
	logic [IW-1:0]     slot_id;
	logic              t_wr_en;
	logic [TRAM_W-1:0] t_wr_data;
	logic              t_rd_en;
	logic [TRAM_W-1:0] t_rd_data;

	logic [SW-1:0]     cnt_sum;
	logic              pick_ok;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= QUANTUM_RST;
			idle_mult_q <= IDLE_MULT_RST;
			high_code_q <= HIGH_CODE_RST;
			med_code_q  <= MED_CODE_RST;
			own_cpu_q   <= OWN_CPU_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_QUANTUM:   quantum_q   <= cfg_data;
				CFG_IDLE_MULT: idle_mult_q <= cfg_data[MULT_W-1:0];
				CFG_HIGH_CODE: high_code_q <= cfg_data[PRIO_W-1:0];
				CFG_MED_CODE:  med_code_q  <= cfg_data[PRIO_W-1:0];
				CFG_OWN_CPU:   own_cpu_q   <= cfg_data[CPU_W-1:0];
				default: ;
			endcase
		end
	end

	// Request handshake: one request at a time
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_tick   = (req_data.cmd == CMD_TICK);

	// Map a priority code to its queue; high wins over medium on overlap
	always_comb begin
		priority if (req_data.priority_req == high_code_q) begin
			create_q_sel = Q_HIGH;
		end else if (req_data.priority_req == med_code_q) begin
			create_q_sel = Q_MED;
		end else begin
			create_q_sel = Q_LOW;
		end
	end

	// Pick the highest non-empty queue for a tick
	always_comb begin
		any_ready = 1'b1;
		priority if (cnt_q[0] != '0) begin
			tick_q_sel = Q_HIGH;
		end else if (cnt_q[1] != '0) begin
			tick_q_sel = Q_MED;
		end else if (cnt_q[2] != '0) begin
			tick_q_sel = Q_LOW;
		end else begin
			tick_q_sel = Q_LOW;
			any_ready  = 1'b0;
		end
	end

	assign sel_q    = is_tick ? tick_q_sel : create_q_sel;
	assign cnt_sel  = cnt_q[sel_q];
	assign pick_sel = pick_q[sel_q];

	// Advance the round-robin pointer, wrapping from the head marker or the end
	always_comb begin
		if (pick_sel >= CW'(QUEUE_DEPTH)) begin
			pick_inc = '0;
		end else begin
			pick_inc = pick_sel + 1'b1;
		end
		if (pick_inc >= cnt_sel) begin
			new_pick = '0;
		end else begin
			new_pick = pick_inc;
		end
	end

	assign other_cpu  = (req_data.target_cpu != own_cpu_q);
	assign table_full = (next_q >= NW'(MAX_TASKS)) || (cnt_sel >= CW'(QUEUE_DEPTH));
	assign do_create  = accept && !is_tick && !other_cpu && !table_full;
	assign do_tick    = accept && is_tick && any_ready;

	assign idle_slice = SLICE_W'(quantum_q) * SLICE_W'(idle_mult_q);
	assign task_slice = SLICE_W'(quantum_q) * SLICE_W'(t_rd_data[TRAM_W-1 -: PRIO_W]);

	// Queue slot memory: {queue, slot} -> task id
	assign q_wr_en   = do_create;
	assign q_wr_addr = QAW'({create_q_sel, cnt_sel[QIW-1:0]});
	assign q_rd_en   = do_tick;
	assign q_rd_addr = QAW'({tick_q_sel, new_pick[QIW-1:0]});

	mrrs_ram #(
		.WIDTH (IW),
		.DEPTH (QRAM_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_wr_en),
		.wr_addr (q_wr_addr),
		.wr_data (next_q[IW-1:0]),
		.rd_en   (q_rd_en),
		.rd_addr (q_rd_addr),
		.rd_data (q_rd_data)
	);

	// Clamp an id beyond the table to task zero
	assign slot_id = ({1'b0, q_rd_data} >= (IW + 1)'(MAX_TASKS)) ? '0 : q_rd_data;

	// Task table: id -> {priority, entry address}
	assign t_wr_en   = do_create;
	assign t_wr_data = {req_data.priority_req, req_data.entry_addr};
	assign t_rd_en   = (state_q == S_SLOT);

	mrrs_ram #(
		.WIDTH (TRAM_W),
		.DEPTH (MAX_TASKS)
	) u_task_ram (
		.clk     (clk),
		.wr_en   (t_wr_en),
		.wr_addr (next_q[IW-1:0]),
		.wr_data (t_wr_data),
		.rd_en   (t_rd_en),
		.rd_addr (slot_id),
		.rd_data (t_rd_data)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;

	// Sequencer, queue bookkeeping and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_q      <= '0;
			id_q        <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				cnt_q[i]  <= '0;
				pick_q[i] <= CW'(QUEUE_DEPTH);
			end
		end else begin
			// drop the response once taken, unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!is_tick) begin
							state_q <= S_OUT;
							if (other_cpu) begin
								res_q <= '{status: ST_OTHER_CPU, task_id: '0,
									task_addr: '0, slice_ticks: '0};
							end else if (table_full) begin
								res_q <= '{status: ST_FULL, task_id: '0,
									task_addr: '0, slice_ticks: '0};
							end else begin
								cnt_q[sel_q] <= cnt_sel + 1'b1;
								next_q       <= next_q + 1'b1;
								res_q <= '{status: ST_CREATED,
									task_id: TASK_ID_W'(next_q),
									task_addr: '0, slice_ticks: '0};
							end
						end else if (!any_ready) begin
							state_q <= S_OUT;
							res_q <= '{status: ST_IDLE, task_id: '0,
								task_addr: '0, slice_ticks: idle_slice};
						end else begin
							pick_q[sel_q] <= new_pick;
							state_q       <= S_SLOT;
						end
					end
				end
				S_SLOT: begin
					id_q    <= slot_id;
					state_q <= S_TASK;
				end
				S_TASK: begin
					res_q.status      <= ST_DISPATCHED;
					res_q.task_id     <= TASK_ID_W'(id_q);
					res_q.task_addr   <= t_rd_data[ADDR_W-1:0];
					res_q.slice_ticks <= task_slice;
					state_q           <= S_OUT;
				end
				S_OUT: begin
					// hand over once the output register frees
					if (out_free) begin
						rsp_data_q  <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// Invariants for checking
	assign cnt_sum = SW'(cnt_q[0]) + SW'(cnt_q[1]) + SW'(cnt_q[2]);

	always_comb begin
		pick_ok = 1'b1;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (pick_q[i] != CW'(QUEUE_DEPTH) && pick_q[i] >= cnt_q[i]) begin
				pick_ok = 1'b0;
			end
		end
	end

	`MRRS_ASSERT_NOW(a_count_matches_tasks, clk, arst_n, 1'b1, cnt_sum == SW'(next_q),
		"queue occupancy differs from number of created tasks")
	`MRRS_ASSERT_NOW(a_pick_in_range, clk, arst_n, 1'b1, pick_ok,
		"round-robin pointer beyond its queue")
	`MRRS_ASSERT_NEXT(a_create_step, clk, arst_n, accept && !is_tick,
		next_q == $past(next_q) || next_q == $past(next_q) + 1'b1,
		"task numbering moved by more than one")
	`MRRS_ASSERT_NOW(a_queue_ram_interlock, clk, arst_n, q_wr_en, !q_rd_en && !t_rd_en,
		"queue write overlaps a read")

endmodule

// ----- hdl/mrrs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mrrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the multilevel round-robin task scheduler.
// Depends on mrrs_pkg and the multilevel_round_robin_scheduler RTL; it mirrors
// the task table and run queues in SystemVerilog and checks every response.
`timescale 1ns / 100ps

module tb_top;
	import mrrs_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_BATCHES = 12;
	localparam int BATCH_ITEMS    = 100;
	localparam int CREATE_CAP     = 58;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_item_t             req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_item_t             rsp_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// No gaps on either side while set
	logic quiet = 1'b0;

	// Mirror of the task table, run queues and registers
	logic [ADDR_W-1:0]    task_addr_m [MAX_TASKS_DEF];
	logic [PRIO_W-1:0]    task_prio_m [MAX_TASKS_DEF];
	logic [TASK_ID_W-1:0] run_queue [NUM_QUEUES][QUEUE_DEPTH_DEF];
	int                   run_count [NUM_QUEUES] = '{default: 0};
	int                   run_last [NUM_QUEUES]  = '{default: QUEUE_DEPTH_DEF};
	int                   tasks_made = 0;
	logic [QUANTUM_W-1:0] quantum_m   = QUANTUM_RST;
	logic [MULT_W-1:0]    idle_mult_m = IDLE_MULT_RST;
	logic [PRIO_W-1:0]    high_code_m = HIGH_CODE_RST;
	logic [PRIO_W-1:0]    med_code_m  = MED_CODE_RST;
	logic [CPU_W-1:0]     own_cpu_m   = OWN_CPU_RST;

	rsp_item_t awaited_rsp [$];
	int        errors        = 0;
	int        still_cycles  = 0;
	int        rsp_phase_left = 0;

	multilevel_round_robin_scheduler #(
		.MAX_TASKS   (MAX_TASKS_DEF),
		.QUEUE_DEPTH (QUEUE_DEPTH_DEF)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Apply one request to the mirror and return the response it causes
	function automatic rsp_item_t schedule_outcome(input req_item_t r);
		rsp_item_t            o;
		logic [QSEL_W-1:0]    q;
		logic [TASK_ID_W-1:0] id;
		int                   pick;
		o = '0;
		if (r.cmd == CMD_CREATE) begin
			if (r.target_cpu != own_cpu_m) begin
				o.status = ST_OTHER_CPU;
				return o;
			end
			// High code wins over an equal medium code
			if (r.priority_req == high_code_m)
				q = Q_HIGH;
			else if (r.priority_req == med_code_m)
				q = Q_MED;
			else
				q = Q_LOW;
			if (tasks_made >= MAX_TASKS_DEF || run_count[q] >= QUEUE_DEPTH_DEF) begin
				o.status = ST_FULL;
				return o;
			end
			id = TASK_ID_W'(tasks_made);
			task_addr_m[id] = r.entry_addr;
			task_prio_m[id] = r.priority_req;
			run_queue[q][run_count[q]] = id;
			run_count[q]++;
			tasks_made++;
			o.status = ST_CREATED;
			o.task_id = id;
			return o;
		end
		if (run_count[Q_HIGH] != 0)
			q = Q_HIGH;
		else if (run_count[Q_MED] != 0)
			q = Q_MED;
		else if (run_count[Q_LOW] != 0)
			q = Q_LOW;
		else begin
			o.status = ST_IDLE;
			o.slice_ticks = SLICE_W'(int'(quantum_m) * int'(idle_mult_m));
			return o;
		end
		// Advance the round-robin pointer, wrapping past the last slot
		pick = run_last[q];
		if (pick >= QUEUE_DEPTH_DEF)
			pick = 0;
		else
			pick++;
		if (pick >= run_count[q])
			pick = 0;
		run_last[q] = pick;
		id = run_queue[q][pick];
		o.status = ST_DISPATCHED;
		o.task_id = id;
		o.task_addr = task_addr_m[id];
		o.slice_ticks = SLICE_W'(int'(quantum_m) * int'(task_prio_m[id]));
		return o;
	endfunction

	function automatic req_item_t create_request(input logic [PRIO_W-1:0] prio,
			input logic [ADDR_W-1:0] addr, input logic [CPU_W-1:0] cpu);
		req_item_t r;
		r.cmd = CMD_CREATE;
		r.priority_req = prio;
		r.entry_addr = addr;
		r.target_cpu = cpu;
		return r;
	endfunction

	// Tick with random content in the fields it does not use
	function automatic req_item_t tick_request();
		req_item_t r;
		r.cmd = CMD_TICK;
		r.priority_req = PRIO_W'($urandom);
		r.entry_addr = {$urandom, $urandom};
		r.target_cpu = CPU_W'($urandom);
		return r;
	endfunction

	// Send one request, record its expected response, then maybe idle
	task automatic send_request(input req_item_t r);
		int gap;
		req_data <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		awaited_rsp.push_back(schedule_outcome(r));
		gap = gap_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold requests until every response is back and the block has settled
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register index, the unused ones with junk
	task automatic set_config(input logic [QUANTUM_W-1:0] quant, input logic [MULT_W-1:0] mult,
			input logic [PRIO_W-1:0] hcode, input logic [PRIO_W-1:0] mcode,
			input logic [CPU_W-1:0] cpu);
		int                    i;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		drain_responses();
		for (i = 0; i < (1 << CFG_IDX_W); i++) begin
			idx = CFG_IDX_W'(i);
			value = CFG_DATA_W'($urandom);
			case (idx)
				CFG_QUANTUM:   value = quant;
				CFG_IDLE_MULT: value[MULT_W-1:0] = mult;
				CFG_HIGH_CODE: value[PRIO_W-1:0] = hcode;
				CFG_MED_CODE:  value[PRIO_W-1:0] = mcode;
				CFG_OWN_CPU:   value[CPU_W-1:0] = cpu;
				default: ;
			endcase
			cfg_index <= idx;
			cfg_data <= value;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx)
				CFG_QUANTUM:   quantum_m = value;
				CFG_IDLE_MULT: idle_mult_m = value[MULT_W-1:0];
				CFG_HIGH_CODE: high_code_m = value[PRIO_W-1:0];
				CFG_MED_CODE:  med_code_m = value[PRIO_W-1:0];
				CFG_OWN_CPU:   own_cpu_m = value[CPU_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Idle ticks across the slice extremes, zero quantum and multiplier too
	task automatic test_idle_ticks();
		send_request(tick_request());
		set_config(8'd255, 4'd15, HIGH_CODE_RST, MED_CODE_RST, OWN_CPU_RST);
		send_request(tick_request());
		set_config(8'd1, 4'd1, HIGH_CODE_RST, MED_CODE_RST, OWN_CPU_RST);
		send_request(tick_request());
		set_config(8'd0, 4'd0, HIGH_CODE_RST, MED_CODE_RST, OWN_CPU_RST);
		send_request(tick_request());
	endtask

	// Creates for another CPU change nothing
	task automatic test_other_cpu();
		set_config(8'd5, 4'd5, HIGH_CODE_RST, MED_CODE_RST, 4'd15);
		send_request(create_request(4'd3, '1, 4'd0));
		send_request(create_request(4'd15, 64'h0123_4567_89AB_CDEF, 4'd14));
		set_config(8'd5, 4'd5, HIGH_CODE_RST, MED_CODE_RST, 4'd0);
		send_request(create_request(4'd0, '0, 4'd15));
		send_request(tick_request());
	endtask

	// Low queue only: zero priority, top priority, pointer wrap
	task automatic test_low_queue();
		set_config(8'd17, 4'd5, HIGH_CODE_RST, MED_CODE_RST, 4'd0);
		send_request(create_request(4'd0, '0, 4'd0));
		send_request(create_request(4'd15, '1, 4'd0));
		send_request(create_request(4'd1, 64'hA5A5_A5A5_5A5A_5A5A, 4'd0));
		repeat (4) send_request(tick_request());
	endtask

	// Medium queue takes over from the low queue
	task automatic test_med_queue();
		send_request(create_request(MED_CODE_RST, 64'h5555_5555_5555_5555, 4'd0));
		send_request(create_request(MED_CODE_RST, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0));
		repeat (2) send_request(tick_request());
	endtask

	// Equal high and medium codes: the high queue wins
	task automatic test_high_queue();
		set_config(8'd255, 4'd5, 4'd7, 4'd7, 4'd0);
		send_request(create_request(4'd7, 64'hFEDC_BA98_7654_3210, 4'd0));
		repeat (2) send_request(tick_request());
	endtask

	// Mostly ticks; creates mostly for other CPUs so the table fills slowly
	task automatic test_random_traffic();
		int        batch;
		int        n;
		req_item_t r;
		logic [QUANTUM_W-1:0] quant;
		logic [MULT_W-1:0]    mult;
		for (batch = 0; batch < RANDOM_BATCHES; batch++) begin
			case ($urandom_range(0, 3))
				0: quant = 8'd1;
				1: quant = 8'd255;
				default: quant = QUANTUM_W'($urandom_range(1, 255));
			endcase
			case ($urandom_range(0, 3))
				0: mult = 4'd1;
				1: mult = 4'd15;
				default: mult = MULT_W'($urandom_range(1, 15));
			endcase
			set_config(quant, mult, PRIO_W'($urandom), PRIO_W'($urandom), CPU_W'($urandom));
			quiet <= (batch % 4 == 3);
			for (n = 0; n < BATCH_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					r = tick_request();
				end else begin
					r = create_request(PRIO_W'($urandom), {$urandom, $urandom},
						own_cpu_m + CPU_W'($urandom_range(1, 15)));
					if ($urandom_range(0, 99) < 18 && tasks_made < CREATE_CAP)
						r.target_cpu = own_cpu_m;
				end
				send_request(r);
				if ($urandom_range(0, 199) == 0)
					drain_responses();
			end
		end
		quiet <= 1'b0;
	endtask

	// Fill the table to the last id, then creates must report full
	task automatic test_table_full();
		while (tasks_made < MAX_TASKS_DEF) begin
			send_request(create_request(PRIO_W'($urandom), {$urandom, $urandom}, own_cpu_m));
			if ($urandom_range(0, 2) == 0)
				send_request(tick_request());
		end
		repeat (6) send_request(create_request(PRIO_W'($urandom), {$urandom, $urandom},
			own_cpu_m));
		repeat (4) send_request(tick_request());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_other_cpu();
		test_low_queue();
		test_med_queue();
		test_high_queue();
		test_random_traffic();
		test_table_full();
		drain_responses();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Alternate random stall stretches with open stretches
	always @(posedge clk) begin
		if (rsp_phase_left > 0) begin
			rsp_phase_left--;
		end else if (quiet || rsp_stall) begin
			rsp_stall <= 1'b0;
			rsp_phase_left = $urandom_range(1, 12);
		end else begin
			rsp_phase_left = gap_length();
			if (rsp_phase_left > 0)
				rsp_stall <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each accepted response with the oldest expected one
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual 0x%0h", $time,
					rsp_data);
				errors++;
			end else begin
				want = awaited_rsp.pop_front();
				check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_data.status));
				check_field("task_id", ADDR_W'(want.task_id), ADDR_W'(rsp_data.task_id));
				check_field("task_addr", want.task_addr, rsp_data.task_addr);
				check_field("slice_ticks", ADDR_W'(want.slice_ticks),
					ADDR_W'(rsp_data.slice_ticks));
			end
		end
	end

	// End the run when no handshake happens for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			still_cycles <= 0;
		else
			still_cycles <= still_cycles + 1;
		if (still_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
				IDLE_LIMIT, awaited_rsp.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
